FILE: design/pfes_pkg.sv
// Shared types and constants for the every-second-prime filter.
package pfes_pkg;

    localparam int OUT_WIDTH = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_LOOP,
        ST_DIVIDE,
        ST_TEST,
        ST_PRIME
    } state_t;

    typedef struct packed {
        logic load;          // capture input item, apply start flag
        logic init_trial;    // divisor = 3, square = 9
        logic rem_start;     // begin remainder for current divisor
        logic rem_step;      // one restoring-division bit
        logic next_divisor;  // divisor += 2
        logic commit_prime;  // flip parity, bump count when it returns to zero
        logic emit;          // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic not_prime;     // negative, below 2, or even and at least 4
        logic small_prime;   // 2 or 3
        logic square_gt;     // divisor squared exceeds value
        logic rem_last;      // current step is the last remainder bit
        logic rem_zero;      // divisor divides value
        logic parity;        // odd number of primes seen so far
        logic out_free;      // output register can take a result this cycle
    } dp_status_t;

endpackage

FILE: design/pfes_dp.sv
// Datapath: value, trial divisor and square, bit-serial remainder, output register.
module pfes_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [VALUE_WIDTH-1:0]         s_number_value,
    input  logic                           s_start_of_list,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [pfes_pkg::OUT_WIDTH-1:0] m_prime_value,
    output logic [pfes_pkg::OUT_WIDTH-1:0] m_emitted_count,
    input  pfes_pkg::dp_cmd_t              cmd,
    output pfes_pkg::dp_status_t           status
);

    localparam int W   = VALUE_WIDTH;
    localparam int OW  = pfes_pkg::OUT_WIDTH;
    localparam int IW  = $clog2(W);

    logic [W-1:0]  value_reg, value_next;
    logic [W-1:0]  div_reg, div_next;
    logic [W:0]    sq_reg, sq_next;
    logic [W:0]    rem_reg, rem_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          parity_reg, parity_next;
    logic [OW-1:0] count_reg, count_next;
    logic          m_valid_reg, m_valid_next;
    logic [OW-1:0] prime_reg, prime_next;
    logic [OW-1:0] emitted_reg, emitted_next;

    logic [W:0]    rem_trial;
    logic [W:0]    div_ext;
    logic [OW-1:0] value_ext;

    assign div_ext   = {1'b0, div_reg};
    assign rem_trial = {rem_reg[W-1:0], value_reg[idx_reg]};
    assign value_ext = OW'(value_reg);

    always_comb begin
        value_next   = value_reg;
        div_next     = div_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        idx_next     = idx_reg;
        parity_next  = parity_reg;
        count_next   = count_reg;
        prime_next   = prime_reg;
        emitted_next = emitted_reg;
        m_valid_next = m_valid_reg & ~m_ready;

        if (cmd.load) begin
            value_next = s_number_value;
            if (s_start_of_list) begin
                parity_next = 1'b0;
                count_next  = '0;
            end
        end
        if (cmd.init_trial) begin
            div_next = W'(3);
            sq_next  = (W+1)'(9);
        end
        if (cmd.next_divisor) begin
            div_next = div_reg + W'(2);
            // (d+2)^2 = d^2 + 4d + 4
            sq_next  = sq_reg + (W+1)'({div_reg, 2'b00}) + (W+1)'(4);
        end
        if (cmd.rem_start) begin
            rem_next = '0;
            idx_next = IW'(W - 1);
        end
        if (cmd.rem_step) begin
            if (rem_trial >= div_ext) begin
                rem_next = rem_trial - div_ext;
            end else begin
                rem_next = rem_trial;
            end
            idx_next = idx_reg - IW'(1);
        end
        if (cmd.commit_prime) begin
            parity_next = ~parity_reg;
            if (parity_reg) begin
                count_next = count_reg + OW'(1);
            end
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            prime_next   = value_ext;
            emitted_next = count_reg + OW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            parity_reg  <= parity_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        div_reg     <= div_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        prime_reg   <= prime_next;
        emitted_reg <= emitted_next;
    end

    assign status.not_prime   = value_reg[W-1] || (value_reg < W'(2))
                                || ((value_reg >= W'(4)) && !value_reg[0]);
    assign status.small_prime = (value_reg == W'(2)) || (value_reg == W'(3));
    assign status.square_gt   = sq_reg > {1'b0, value_reg};
    assign status.rem_last    = (idx_reg == '0);
    assign status.rem_zero    = (rem_reg == '0);
    assign status.parity      = parity_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_prime_value   = prime_reg;
    assign m_emitted_count = emitted_reg;

endmodule

FILE: design/pfes_ctrl.sv
// Controller state machine sequencing classification, trial division and emit.
module pfes_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pfes_pkg::dp_status_t status,
    output pfes_pkg::dp_cmd_t    cmd
);

    pfes_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfes_pkg::ST_IDLE: begin
                if (s_valid) state_next = pfes_pkg::ST_CLASSIFY;
            end
            pfes_pkg::ST_CLASSIFY: begin
                if (status.not_prime) begin
                    state_next = pfes_pkg::ST_IDLE;
                end else if (status.small_prime) begin
                    state_next = pfes_pkg::ST_PRIME;
                end else begin
                    state_next = pfes_pkg::ST_LOOP;
                end
            end
            pfes_pkg::ST_LOOP: begin
                if (status.square_gt) begin
                    state_next = pfes_pkg::ST_PRIME;
                end else begin
                    state_next = pfes_pkg::ST_DIVIDE;
                end
            end
            pfes_pkg::ST_DIVIDE: begin
                if (status.rem_last) state_next = pfes_pkg::ST_TEST;
            end
            pfes_pkg::ST_TEST: begin
                if (status.rem_zero) begin
                    state_next = pfes_pkg::ST_IDLE;
                end else begin
                    state_next = pfes_pkg::ST_LOOP;
                end
            end
            pfes_pkg::ST_PRIME: begin
                // even-numbered prime waits for the output register to free up
                if (!status.parity || status.out_free) state_next = pfes_pkg::ST_IDLE;
            end
            default: state_next = pfes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pfes_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            pfes_pkg::ST_CLASSIFY: begin
                cmd.init_trial = !status.not_prime && !status.small_prime;
            end
            pfes_pkg::ST_LOOP: begin
                cmd.rem_start = !status.square_gt;
            end
            pfes_pkg::ST_DIVIDE: begin
                cmd.rem_step = 1'b1;
            end
            pfes_pkg::ST_TEST: begin
                cmd.next_divisor = !status.rem_zero;
            end
            pfes_pkg::ST_PRIME: begin
                if (!status.parity) begin
                    cmd.commit_prime = 1'b1;
                end else if (status.out_free) begin
                    cmd.commit_prime = 1'b1;
                    cmd.emit         = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfes_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/prime_filter_every_second_unit.sv
// Top level of the every-second-prime filter: controller plus datapath.
//
// Input channel s_*: one signed integer per transfer with a start-of-list flag
// that clears the prime parity and emitted count before the value is used.
// Output channel m_*: every second prime of the list with its running count.
// Values that are negative, below 2, or composite produce no output transfer.
//
// Timing: one item at a time. After the input transfer, the CLASSIFY state
// classifies the value (sign, below 2, 2 or 3, even). Each odd trial divisor d
// then passes a square check, the one-bit-per-cycle restoring remainder unit
// over all VALUE_WIDTH bits of the value, and a zero test. A composite stops at
// its first divisor. s_ready is high only while the block is idle.
//
// The result sits in an output register, so a stalled receiver blocks only
// when a further result is ready to load; items that emit nothing keep flowing.
// Reset (aresetn low, synchronous) clears parity, count and the output valid.
module prime_filter_every_second_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [VALUE_WIDTH-1:0]         s_number_value,
    input  logic                           s_start_of_list,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pfes_pkg::OUT_WIDTH-1:0] m_prime_value,
    output logic [pfes_pkg::OUT_WIDTH-1:0] m_emitted_count
);

    pfes_pkg::dp_cmd_t    cmd;
    pfes_pkg::dp_status_t status;

    pfes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pfes_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_number_value  (s_number_value),
        .s_start_of_list (s_start_of_list),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_prime_value   (m_prime_value),
        .m_emitted_count (m_emitted_count),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

FILE: verif/tb_prime_filter_every_second_unit.sv
// Testbench for the every-second-prime filter: directed lists, output stall, random lists.
module tb_prime_filter_every_second_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W = 32;

    typedef struct packed {
        logic [pfes_pkg::OUT_WIDTH-1:0] prime;
        logic [pfes_pkg::OUT_WIDTH-1:0] count;
    } prime_result_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;
    typedef enum {NOISE_NEGATIVE, NOISE_TINY, NOISE_MULT3, NOISE_EVEN} noise_kind_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [VALUE_W-1:0]             s_number_value;
    logic                           s_start_of_list;
    logic                           m_valid;
    logic                           m_ready;
    logic [pfes_pkg::OUT_WIDTH-1:0] m_prime_value;
    logic [pfes_pkg::OUT_WIDTH-1:0] m_emitted_count;

    prime_result_t                  awaited_primes[$];
    logic                           list_parity = 1'b0;
    logic [pfes_pkg::OUT_WIDTH-1:0] list_emitted = '0;
    int                             error_count = 0;
    int                             burst_left = 0;
    bit                             gaps_enabled = 1'b1;
    int                             hold_request = 0;

    prime_filter_every_second_unit #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_number_value (s_number_value),
        .s_start_of_list(s_start_of_list),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prime_value  (m_prime_value),
        .m_emitted_count(m_emitted_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit trial_prime(input longint unsigned v);
        if (v < 2) return 1'b0;
        if (v < 4) return 1'b1;
        if (v[0] == 1'b0) return 1'b0;
        for (longint unsigned d = 3; d <= v / d; d += 2) begin
            if (v % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // every prime toggles parity; the one bringing it back to zero is emitted
    function automatic void track_prime_parity(input logic [VALUE_W-1:0] value,
                                               input logic start);
        if (start) begin
            list_parity  = 1'b0;
            list_emitted = '0;
        end
        if (!value[VALUE_W-1] && trial_prime(value)) begin
            list_parity = ~list_parity;
            if (!list_parity) begin
                list_emitted = list_emitted + 1'b1;
                awaited_primes.push_back('{prime: value[pfes_pkg::OUT_WIDTH-1:0],
                                           count: list_emitted});
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // returns in the step of the accepting edge with valid still high
    task automatic send_number(input logic [VALUE_W-1:0] value, input logic start);
        if (gaps_enabled && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_valid         <= 1'b1;
        s_number_value  <= value;
        s_start_of_list <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_prime_parity(value, start);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (awaited_primes.size() != 0) @(posedge aclk);
    endtask

    task automatic test_non_primes();
        send_number(32'h8000_0000, 1'b1);
        send_number(32'hFFFF_FFFF, 1'b0);
        send_number(32'd0, 1'b0);
        send_number(32'd1, 1'b0);
        send_number(32'd4, 1'b0);
        send_number(32'd9, 1'b0);
        send_number(32'd25, 1'b0);
        send_number(32'd15, 1'b0);
        wait_for_results();
    endtask

    task automatic test_small_primes();
        send_number(32'd2, 1'b0);
        send_number(32'd3, 1'b0);
        send_number(32'd5, 1'b0);
        send_number(32'd7, 1'b0);
        wait_for_results();
    endtask

    // odd prime left over at list end, start flag on a prime and on a negative
    task automatic test_list_restart();
        send_number(32'd11, 1'b0);
        send_number(32'd13, 1'b1);
        send_number(-32'sd7, 1'b1);
        send_number(32'd17, 1'b0);
        send_number(32'd19, 1'b0);
        wait_for_results();
    endtask

    task automatic test_largest_values();
        send_number(32'd2, 1'b1);
        send_number(32'h7FFF_FFFF, 1'b0);
        send_number(32'h7FFF_FFFE, 1'b0);
        send_number(32'h7FFF_FFFD, 1'b0);
        wait_for_results();
    endtask

    // receiver holds off while results pile up, input must stall
    task automatic test_output_stall();
        gaps_enabled = 1'b0;
        hold_request = 2000;
        send_number(32'd2, 1'b1);
        send_number(32'd3, 1'b0);
        send_number(32'd5, 1'b0);
        send_number(32'd7, 1'b0);
        send_number(32'd11, 1'b0);
        send_number(32'd13, 1'b0);
        send_number(32'd17, 1'b0);
        send_number(32'd19, 1'b0);
        gaps_enabled = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_lists();
        int             counted = 0;
        int             list_len;
        logic [VALUE_W-1:0] v;
        noise_kind_t    kind;
        while (counted < 70) begin
            if ($urandom_range(0, 3) == 0) begin
                kind = noise_kind_t'($urandom_range(0, 3));
                case (kind)
                    NOISE_NEGATIVE: v = {1'b1, 31'($urandom)};
                    NOISE_TINY:     v = $urandom_range(0, 1);
                    NOISE_MULT3: begin
                        // large but divisible by 3: odd ones stop at the first trial divisor
                        v = {1'b0, 31'($urandom)};
                        v = v - v % 3;
                    end
                    default:        v = {1'b0, 31'($urandom)} & ~32'h1;
                endcase
                send_number(v, $urandom_range(0, 7) == 0);
            end else begin
                list_len = $urandom_range(1, 9);
                for (int k = 0; k < list_len; k++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        v = $urandom_range(0, 16383);
                    end else begin
                        v = $urandom_range(2, 16383);
                        while (!trial_prime(v)) v = $urandom_range(2, 16383);
                    end
                    send_number(v, k == 0);
                    counted++;
                end
            end
            if ($urandom_range(0, 15) == 0) wait_for_results();
        end
        wait_for_results();
    endtask

    // receiver: random stall modes in stretches, plus a long hold on request
    initial begin
        int       hold_left;
        int       phase_left;
        rx_mode_t mode;
        hold_left  = 0;
        phase_left = 0;
        mode       = RX_OPEN;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    mode       = rx_mode_t'($urandom_range(0, 2));
                    phase_left = $urandom_range(16, 200);
                end
                phase_left--;
                case (mode)
                    RX_OPEN:  m_ready <= 1'b1;
                    RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                    default:  m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_results
        prime_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_primes.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer prime %0d count %0d",
                                          m_prime_value, m_emitted_count));
            end else begin
                want = awaited_primes.pop_front();
                if (m_prime_value !== want.prime)
                    report_mismatch($sformatf("prime_value %0d, expected %0d",
                                              m_prime_value, want.prime));
                if (m_emitted_count !== want.count)
                    report_mismatch($sformatf("emitted_count %0d, expected %0d",
                                              m_emitted_count, want.count));
            end
        end
    end

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_number_value  <= '0;
        s_start_of_list <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_non_primes();
        test_small_primes();
        test_list_restart();
        test_largest_values();
        test_output_stall();
        test_random_lists();

        // let a stray transfer show up after the last item
        repeat (5000) @(posedge aclk);
        if (awaited_primes.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_primes.size()));
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #(64'd100_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
